>>> design/tsdm_pkg.sv
// ============================================================================
// tsdm_pkg
// Shared types and constants of the transport stream discontinuity marker.
// ============================================================================
`default_nettype none

package tsdm_pkg;

    // Packet geometry and PID space
    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = 8;
    localparam int PID_W        = 13;
    localparam int PID_SPACE    = 8192;
    localparam int COUNT_W      = 14;

    // Segment tag stored per PID; tag zero means "never seen"
    localparam int EPOCH_W      = 16;

    // Header constants
    localparam logic [7:0] SYNC_VALUE = 8'h47;
    localparam logic [7:0] DISC_BIT   = 8'h80;

    // Byte positions of interest within a packet
    localparam logic [POS_W-1:0] POS_SYNC   = 8'd0;
    localparam logic [POS_W-1:0] POS_PID_HI = 8'd1;
    localparam logic [POS_W-1:0] POS_PID_LO = 8'd2;
    localparam logic [POS_W-1:0] POS_AFC    = 8'd3;
    localparam logic [POS_W-1:0] POS_AF_LEN = 8'd4;
    localparam logic [POS_W-1:0] POS_MARK   = 8'd5;
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PACKET_BYTES - 1);

    // Input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_start;
        logic       in_full_packet;
    } in_t;

    // Result
    typedef struct packed {
        logic [7:0]         out_byte;
        logic               was_marked;
        logic [COUNT_W-1:0] marked_total;
    } out_t;

    // Core to PID map
    typedef struct packed {
        logic             seg_pending;
        logic             seg_accept;
        logic             rd_en;
        logic             wr_en;
        logic [PID_W-1:0] addr;
    } map_req_t;

    // PID map to core
    typedef struct packed {
        logic hold;
        logic seen;
    } map_status_t;

endpackage

`default_nettype wire

>>> design/tsdm_ram.sv
// ============================================================================
// tsdm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
`default_nettype none

module tsdm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/tsdm_pidmap.sv
// ============================================================================
// tsdm_pidmap
// Per-PID seen map held as segment tags in RAM, with wrap clearing pass.
// ============================================================================
`default_nettype none

module tsdm_pidmap
    import tsdm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire map_req_t    req,
    output map_status_t      status
);

    logic               clr_active_reg, clr_active_next;
    logic [PID_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               rd_pend_reg;
    logic               seen_reg;

    logic               epoch_full;
    logic               start_clr;
    logic               ram_we;
    logic [PID_W-1:0]   ram_waddr;
    logic [EPOCH_W-1:0] ram_wdata;
    logic [EPOCH_W-1:0] ram_rdata;

    assign epoch_full = &epoch_reg;
    assign start_clr  = req.seg_pending & epoch_full & ~clr_active_reg;

    // Hold the source while clearing or about to wrap the tag
    assign status.hold = clr_active_reg | (req.seg_pending & epoch_full);
    assign status.seen = seen_reg;

    // Clearing sweep writes tag zero, otherwise mark writes current tag
    assign ram_we    = clr_active_reg | req.wr_en;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : req.addr;
    assign ram_wdata = clr_active_reg ? '0 : epoch_reg;

    tsdm_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (PID_SPACE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req.rd_en),
        .raddr (req.addr),
        .rdata (ram_rdata)
    );

    // Advance the sweep and the segment tag
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        epoch_next      = epoch_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clr_active_next = 1'b0;
            end
        end
        else if (start_clr)
        begin
            clr_active_next = 1'b1;
            clr_addr_next   = '0;
            epoch_next      = '0;
        end
        else if (req.seg_accept)
        begin
            epoch_next = epoch_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            epoch_reg      <= EPOCH_W'(1);
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            epoch_reg      <= epoch_next;
            rd_pend_reg    <= req.rd_en;
        end
    end

    // Capture the lookup: seen only when tag matches this segment
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            seen_reg <= (ram_rdata == epoch_reg);
        end
    end

    a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !(req.seg_accept || req.wr_en))
        else $error("request taken during clearing pass");

    a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (clr_active_reg && !(&clr_addr_reg)) |=>
            (clr_active_reg && clr_addr_reg == $past(clr_addr_reg) + 1'b1))
        else $error("clearing sweep skipped an entry");

    a_wrap_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) && $past(epoch_reg) == '0 |-> epoch_reg == '0 ||
            epoch_reg == EPOCH_W'(1))
        else $error("segment tag not restarted after wrap clear");

endmodule

`default_nettype wire

>>> design/tsdm_outbuf.sv
// ============================================================================
// tsdm_outbuf
// Two-entry result queue that decouples the core from result stalls.
// ============================================================================
`default_nettype none

module tsdm_outbuf
    import tsdm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire out_t push_data,
    output logic      full,
    output logic      mark_valid,
    input  wire logic mark_stall,
    output out_t      mark_data
);

    out_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign full       = (cnt_reg == 2'd2);
    assign mark_valid = (cnt_reg != 2'd0);
    assign mark_data  = ent_reg[rd_ptr_reg];
    assign pop        = mark_valid & ~mark_stall;

    // Track occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Store the result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("result queue overflow");

endmodule

`default_nettype wire

>>> design/ts_discontinuity_marker_core.sv
// ============================================================================
// ts_discontinuity_marker_core
// Sets the discontinuity indicator on the first adaptation-field packet of
// each PID in a transport stream segment, one byte per cycle while ts_stall is low.
// ============================================================================
//
//  channel | signals                         | direction | payload
//  --------+---------------------------------+-----------+--------
//  ts      | ts_valid, ts_stall, ts_data     | in        | in_t
//  mark    | mark_valid, mark_stall, mark_data| out      | out_t
//
//  One byte is accepted per cycle while ts_stall is low; its result enters the
//  queue at the same edge and is offered on mark once earlier results have left.
//  The PID map lives in an 8192 x 16 RAM of segment tags, read at byte 2
//  and written at byte 5 of each packet.
//  After reset a clearing pass over all 8192 entries holds ts_stall high; the same
//  pass runs again when the segment tag wraps (every 65535 segments).
//  The two-entry result queue keeps input flowing while one result stalls.
// ============================================================================
`default_nettype none

module ts_discontinuity_marker_core
    import tsdm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic ts_valid,
    output logic      ts_stall,
    input  wire in_t  ts_data,
    output logic      mark_valid,
    input  wire logic mark_stall,
    output out_t      mark_data
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               sync_good_reg, sync_good_next;
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic               has_adapt_reg, has_adapt_next;
    logic               af_nonempty_reg, af_nonempty_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               acc;
    logic               q_full;
    logic [POS_W-1:0]   pos_cur;
    logic               marked;
    out_t               result;
    map_req_t           map_req;
    map_status_t        map_status;

    assign ts_stall = map_status.hold | q_full;
    assign acc      = ts_valid & ~ts_stall;

    // Decode header bytes and decide the mark
    always_comb
    begin
        pos_cur          = ts_data.segment_start ? '0 : pos_reg;
        pos_next         = pos_reg;
        sync_good_next   = sync_good_reg;
        pid_next         = pid_reg;
        has_adapt_next   = has_adapt_reg;
        af_nonempty_next = af_nonempty_reg;
        count_next       = count_reg;
        marked           = 1'b0;
        map_req.seg_pending = ts_valid & ts_data.segment_start;
        map_req.seg_accept  = acc & ts_data.segment_start;
        map_req.rd_en       = 1'b0;
        map_req.wr_en       = 1'b0;
        map_req.addr        = pid_reg;

        if (acc)
        begin
            if (ts_data.segment_start)
            begin
                count_next = '0;
            end
            unique case (pos_cur)
                POS_SYNC:
                begin
                    sync_good_next = (ts_data.data_byte == SYNC_VALUE);
                end
                POS_PID_HI:
                begin
                    pid_next[PID_W-1:8] = ts_data.data_byte[PID_W-9:0];
                end
                POS_PID_LO:
                begin
                    pid_next[7:0] = ts_data.data_byte;
                    map_req.rd_en = 1'b1;
                    map_req.addr  = {pid_reg[PID_W-1:8], ts_data.data_byte};
                end
                POS_AFC:
                begin
                    has_adapt_next = ts_data.data_byte[5];
                end
                POS_AF_LEN:
                begin
                    af_nonempty_next = (ts_data.data_byte != 8'd0);
                end
                POS_MARK:
                begin
                    marked = ts_data.in_full_packet & sync_good_reg & has_adapt_reg &
                             af_nonempty_reg & ~map_status.seen;
                    map_req.wr_en = marked;
                end
                default:
                begin
                end
            endcase
            if (marked)
            begin
                count_next = count_next + 1'b1;
            end
            pos_next = (pos_cur == POS_LAST) ? '0 : pos_cur + 1'b1;
        end

        result.out_byte     = ts_data.data_byte | (marked ? DISC_BIT : 8'd0);
        result.was_marked   = marked;
        result.marked_total = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            sync_good_reg   <= 1'b0;
            pid_reg         <= '0;
            has_adapt_reg   <= 1'b0;
            af_nonempty_reg <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            pos_reg         <= pos_next;
            sync_good_reg   <= sync_good_next;
            pid_reg         <= pid_next;
            has_adapt_reg   <= has_adapt_next;
            af_nonempty_reg <= af_nonempty_next;
            count_reg       <= count_next;
        end
    end

    tsdm_pidmap u_pidmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (map_req),
        .status (map_status)
    );

    tsdm_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (acc),
        .push_data  (result),
        .full       (q_full),
        .mark_valid (mark_valid),
        .mark_stall (mark_stall),
        .mark_data  (mark_data)
    );

endmodule

`default_nettype wire
